FILE: sv/sfd_pkg.sv
// Shared types, constants and helpers of the scrambled frame decoder.
package sfd_pkg;

  localparam int MaxFrame = 64;
  localparam int AddrW    = $clog2(MaxFrame);
  localparam int CountW   = $clog2(MaxFrame + 1);

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatReject = 2'd1;
  localparam logic [1:0] StatLength = 2'd2;

  localparam logic [7:0] CmdA = 8'h3f;
  localparam logic [7:0] CmdB = 8'h6f;
  localparam logic [7:0] CmdC = 8'h4e;
  localparam logic [7:0] CmdD = 8'h5e;
  localparam logic [7:0] CmdE = 8'hbb;
  localparam logic [7:0] CmdF = 8'hcc;
  localparam logic [7:0] CmdG = 8'h2f;

  // Store write port from the front end
  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  addr;
    logic [7:0]        data;
  } wr_t;

  // One received frame, classified
  typedef struct packed {
    logic [CountW-1:0] n;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;
    logic [7:0]        b3;
    logic              plain;
  } job_t;

  function automatic logic in_set(input logic [7:0] c);
    return c == CmdA || c == CmdB || c == CmdC || c == CmdD ||
           c == CmdE || c == CmdF || c == CmdG;
  endfunction

  function automatic logic plain_ok(input logic [7:0] c);
    return c == CmdA || c == CmdB || c == CmdC || c == CmdD;
  endfunction

endpackage

FILE: sv/sfd_front.sv
// Front end: takes received bytes, fills the frame store, classifies each frame.
module sfd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data,
  input  logic             in_last,
  input  logic             done,
  output sfd_pkg::wr_t     wr,
  output logic             push,
  output sfd_pkg::job_t    job
);
  import sfd_pkg::*;

  logic [CountW-1:0] count;
  logic [7:0]        b0, b1, b2, b3;
  logic              busy;
  logic              acc;
  logic              room;

  assign in_ready = !busy;
  assign acc      = in_valid && in_ready;
  assign room     = count < CountW'(MaxFrame);

  // Write the byte while the store has room
  assign wr.en   = acc && room;
  assign wr.addr = count[AddrW-1:0];
  assign wr.data = in_data;

  // Describe the frame on its final byte
  always_comb begin
    job.n     = room ? count + CountW'(1) : count;
    job.b0    = (count == CountW'(0)) ? in_data : b0;
    job.b1    = (count == CountW'(1)) ? in_data : b1;
    job.b2    = (count == CountW'(2)) ? in_data : b2;
    job.b3    = (count == CountW'(3)) ? in_data : b3;
    job.plain = in_set(job.b0);
  end
  assign push = acc && in_last;

  // Count bytes, capture header bytes, hold off while a frame decodes
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
    end else begin
      if (done) busy <= 1'b0;
      if (acc) begin
        if (in_last) begin
          count <= '0;
          busy  <= 1'b1;
        end else if (room) begin
          count <= count + CountW'(1);
        end
      end
    end
    if (acc) begin
      b0 <= job.b0;
      b1 <= job.b1;
      b2 <= job.b2;
      b3 <= job.b3;
    end
  end

endmodule

FILE: sv/sfd_queue.sv
// Two-entry queue of frame descriptors between front and back end.
module sfd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfd_pkg::job_t din,
  input  logic          pop,
  output logic          not_empty,
  output sfd_pkg::job_t dout
);
  import sfd_pkg::*;

  job_t       slot [2];
  logic       wp, rp;
  logic [1:0] fill;

  assign not_empty = fill != 2'd0;
  assign dout      = slot[rp];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && fill != 2'd2) wp <= !wp;
      if (pop && not_empty) rp <= !rp;
      if ((push && fill != 2'd2) && !(pop && not_empty)) fill <= fill + 2'd1;
      else if (!(push && fill != 2'd2) && (pop && not_empty)) fill <= fill - 2'd1;
    end
    if (push && fill != 2'd2) slot[wp] <= din;
  end

endmodule

FILE: sv/sfd_back.sv
// Back end: frame store, checksum walk for both keys, result emission.
module sfd_back (
  input  logic          clk,
  input  logic          rst,
  input  sfd_pkg::wr_t  wr,
  input  logic          job_valid,
  input  sfd_pkg::job_t job_in,
  output logic          pop,
  output logic          done,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [55:0]   out_data,
  output logic          out_last
);
  import sfd_pkg::*;

  typedef enum logic [2:0] {IDLE, WALK, DECIDE, EMIT_RD, EMIT_OUT, REJ_OUT} state_t;

  state_t            state;
  job_t              job;
  logic [7:0]        mem [MaxFrame];
  logic [7:0]        rd_data;
  logic [AddrW-1:0]  rd_addr;
  logic [CountW-1:0] iss;
  logic              pv;
  logic [AddrW-1:0]  pidx;
  logic [7:0]        ka, kb, sum_a, sum_b, chk_a, chk_b;
  logic [8:0]        flen_a, flen_b;
  logic [1:0]        ra, rb, rej;
  logic [7:0]        key;
  logic [5:0]        plen, k;
  logic [7:0]        o_cmd, o_type, o_reg, o_chk;
  logic              free;
  logic              emit;

  assign ka     = job.plain ? 8'h00 : job.b2;
  assign kb     = job.b2 ^ 8'h01;
  assign flen_a = {1'b0, job.b1 ^ ka} + 9'd2;
  assign flen_b = {1'b0, job.b1 ^ kb} + 9'd2;
  assign free   = !out_valid || out_ready;
  assign emit   = free && ((state == EMIT_OUT) || (state == REJ_OUT));

  // Judge each key try
  always_comb begin
    logic bad_a, bad_b;
    bad_a = (job.b1 ^ ka) < 8'd3 || flen_a > {2'b0, job.n};
    bad_b = (job.b1 ^ kb) < 8'd3 || flen_b > {2'b0, job.n};
    if (job.plain) begin
      ra = bad_a ? StatLength
         : (sum_a != chk_a || !plain_ok(job.b0)) ? StatReject : StatOk;
      rb = StatOk;
    end else begin
      ra = !in_set(job.b0 ^ ka) ? StatReject : bad_a ? StatLength
         : (sum_a != chk_a) ? StatReject : StatOk;
      rb = !in_set(job.b0 ^ kb) ? StatReject : bad_b ? StatLength
         : (sum_b != chk_b) ? StatReject : StatOk;
    end
    rej = (ra > rb) ? ra : rb;
  end

  // Read address follows the phase
  always_comb begin
    rd_addr = (state == WALK) ? iss[AddrW-1:0] : AddrW'(6'd4 + k);
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rd_data <= mem[rd_addr];
  end

  assign pop  = (state == IDLE) && job_valid;
  assign done = free && ((state == REJ_OUT) ||
                ((state == EMIT_OUT) && (plen == 6'd0 || k + 6'd1 == plen)));

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      pv        <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            job   <= job_in;
            iss   <= '0;
            pv    <= 1'b0;
            sum_a <= 8'h00;
            sum_b <= 8'h00;
            chk_a <= 8'h00;
            chk_b <= 8'h00;
            state <= (job_in.n < CountW'(3)) ? REJ_OUT : WALK;
          end
        end
        WALK: begin
          pv   <= iss < job.n;
          pidx <= iss[AddrW-1:0];
          if (iss < job.n) iss <= iss + CountW'(1);
          if (pv) begin
            if ({3'b0, pidx} + 9'd1 < flen_a) sum_a <= sum_a + (rd_data ^ ka);
            if ({3'b0, pidx} + 9'd1 == flen_a) chk_a <= rd_data ^ ka;
            if ({3'b0, pidx} + 9'd1 < flen_b) sum_b <= sum_b + (rd_data ^ kb);
            if ({3'b0, pidx} + 9'd1 == flen_b) chk_b <= rd_data ^ kb;
          end
          if (!pv && iss == job.n) state <= DECIDE;
        end
        DECIDE: begin
          k <= 6'd0;
          if (ra == StatOk || (!job.plain && rb == StatOk)) begin
            key    <= (ra == StatOk) ? ka : kb;
            plen   <= (ra == StatOk) ? 6'((job.b1 ^ ka) - 8'd3) : 6'((job.b1 ^ kb) - 8'd3);
            o_cmd  <= job.b0 ^ ((ra == StatOk) ? ka : kb);
            o_type <= job.b2 ^ ((ra == StatOk) ? ka : kb);
            o_reg  <= job.b3 ^ ((ra == StatOk) ? ka : kb);
            o_chk  <= (ra == StatOk) ? chk_a : chk_b;
            state  <= EMIT_RD;
          end else begin
            state <= REJ_OUT;
          end
        end
        EMIT_RD: state <= EMIT_OUT;
        EMIT_OUT: begin
          if (free) begin
            out_data  <= {(plen == 6'd0) ? 8'h00 : (rd_data ^ key), key, o_chk,
                          plen, o_reg, o_type, o_cmd, StatOk};
            out_last  <= done;
            k         <= k + 6'd1;
            state     <= done ? IDLE : EMIT_RD;
          end
        end
        REJ_OUT: begin
          if (free) begin
            out_data  <= {54'd0, (job.n < CountW'(3)) ? StatLength : rej};
            out_last  <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: sv/scrambled_frame_decoder_unit.sv
// Top level of the scrambled frame decoder.
// Frame bytes stream in one per cycle with tlast on the final byte; bytes past
// 64 are dropped. Input then stalls while the back end walks the stored frame
// once through a single-port store read (both scrambled keys checked in the
// same pass) and emits one result per payload byte through an output register
// (one result if the payload is empty), or one reject result.
module scrambled_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // raw_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0] command[9:2] frame_type[17:10] register_id[25:18]
  // payload_len[31:26] check_byte[39:32] scramble_key[47:40] payload_byte[55:48]
  output logic [55:0] m_tdata,
  output logic        m_tlast    // last_result
);
  import sfd_pkg::*;

  wr_t  wr;
  job_t job_f, job_q;
  logic push, pop, done, qv;

  sfd_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_data(s_tdata), .in_last(s_tlast), .done(done), .wr(wr),
    .push(push), .job(job_f)
  );

  sfd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(job_f), .pop(pop),
    .not_empty(qv), .dout(job_q)
  );

  sfd_back u_back (
    .clk(clk), .rst(rst), .wr(wr), .job_valid(qv), .job_in(job_q),
    .pop(pop), .done(done), .out_valid(m_tvalid), .out_ready(m_tready),
    .out_data(m_tdata), .out_last(m_tlast)
  );

  a_rej_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != StatOk |-> m_tlast)
    else $error("reject result not marked last");
  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != StatOk |-> m_tdata[55:2] == '0)
    else $error("reject result carries data");
  a_no_code3: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("bad status code");
  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    push |=> !s_tready)
    else $error("input open while frame decodes");

endmodule
